// File: rtl/core/pic_pkg.sv
// Shared types and constants for the programmable interval clock.
// Holds the request/response structs, operation and register codes, and
// control/status bit positions. No dependencies.
package pic_pkg;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		SEL_CSR     = 2'd0,
		SEL_PRESET  = 2'd1,
		SEL_COUNTER = 2'd2
	} sel_t;

	typedef enum logic [1:0] {
		CFG_FAST = 2'd0,
		CFG_SLOW = 2'd1,
		CFG_LINE = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		RATE_STOP = 2'd0,
		RATE_FAST = 2'd1,
		RATE_SLOW = 2'd2,
		RATE_LINE = 2'd3
	} rate_t;

	localparam int unsigned DATA_W = 16;

	// control/status bit positions
	localparam int unsigned CS_GO     = 0;
	localparam int unsigned CS_RATE_L = 1;
	localparam int unsigned CS_RATE_H = 2;
	localparam int unsigned CS_REPEAT = 3;
	localparam int unsigned CS_IE     = 6;
	localparam int unsigned CS_DONE   = 7;

	localparam logic [DATA_W-1:0] DIV_FAST_RST = 16'd10;
	localparam logic [DATA_W-1:0] DIV_SLOW_RST = 16'd98;
	localparam logic [DATA_W-1:0] DIV_LINE_RST = 16'd16384;

	typedef struct packed {
		logic [1:0]        op;
		logic [1:0]        reg_sel;
		logic [DATA_W-1:0] wdata;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] rdata;
		logic              irq;
	} rsp_t;

endpackage

// File: rtl/core/pic_core.sv
// Clock register file, divisor registers and the single-pass update logic.
// Applies one request per step_en and returns its response combinationally.
// Depends on pic_pkg.
module pic_core import pic_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  req_t              req,
	output rsp_t              rsp,
	input  logic              cfg_en,
	input  logic [1:0]        cfg_index,
	input  logic [DATA_W-1:0] cfg_data
);

	logic [DATA_W-1:0] div_fast_q, div_slow_q, div_line_q;
	logic [DATA_W-1:0] csr_q, preset_q, counter_q, prescale_q;
	logic [DATA_W-1:0] csr_d, preset_d, counter_d, prescale_d;
	logic [DATA_W-1:0] div;
	logic [DATA_W:0]   prescale_inc;
	logic              rate_on;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_fast_q <= DIV_FAST_RST;
			div_slow_q <= DIV_SLOW_RST;
			div_line_q <= DIV_LINE_RST;
		end else if (cfg_en) begin
			unique case (cfg_index)
				CFG_FAST: div_fast_q <= cfg_data;
				CFG_SLOW: div_slow_q <= cfg_data;
				CFG_LINE: div_line_q <= cfg_data;
				default:  ; // drop writes past the last register
			endcase
		end
	end

	// divisor selection from the RATE field
	always_comb begin
		rate_on = 1'b1;
		div     = div_fast_q;
		unique case (csr_q[CS_RATE_H:CS_RATE_L])
			RATE_FAST: div = div_fast_q;
			RATE_SLOW: div = div_slow_q;
			RATE_LINE: div = div_line_q;
			default:   rate_on = 1'b0;
		endcase
	end

	assign prescale_inc = {1'b0, prescale_q} + {{DATA_W{1'b0}}, 1'b1};

	always_comb begin
		csr_d      = csr_q;
		preset_d   = preset_q;
		counter_d  = counter_q;
		prescale_d = prescale_q;
		rsp        = '0;
		unique case (req.op)
			OP_TICK: begin
				if (csr_q[CS_GO] && rate_on) begin
					if (prescale_inc < {1'b0, div}) begin
						prescale_d = prescale_inc[DATA_W-1:0];
					end else begin
						prescale_d = '0;
						if (counter_q != '0) begin
							counter_d = counter_q - {{(DATA_W-1){1'b0}}, 1'b1};
						end else begin
							// underflow: flag done, raise irq if enabled, reload or stop
							csr_d[CS_DONE] = 1'b1;
							rsp.irq        = csr_q[CS_IE];
							if (csr_q[CS_REPEAT]) begin
								counter_d = preset_q;
							end else begin
								csr_d[CS_GO] = 1'b0;
							end
						end
					end
				end
			end
			OP_READ: begin
				unique case (req.reg_sel)
					SEL_CSR:     rsp.rdata = csr_q;
					SEL_PRESET:  rsp.rdata = preset_q;
					SEL_COUNTER: rsp.rdata = counter_q;
					default:     rsp.rdata = '0;
				endcase
			end
			OP_WRITE: begin
				unique case (req.reg_sel)
					SEL_CSR: begin
						csr_d = req.wdata;
						if (req.wdata[CS_GO]) begin
							counter_d      = preset_q;
							csr_d[CS_DONE] = 1'b0;
							prescale_d     = '0;
						end
					end
					SEL_PRESET: begin
						preset_d  = req.wdata;
						counter_d = req.wdata;
					end
					SEL_COUNTER: counter_d = req.wdata;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csr_q      <= '0;
			preset_q   <= '0;
			counter_q  <= '0;
			prescale_q <= '0;
		end else if (step_en) begin
			csr_q      <= csr_d;
			preset_q   <= preset_d;
			counter_q  <= counter_d;
			prescale_q <= prescale_d;
		end
	end

endmodule

// File: rtl/core/pic_out_stage.sv
// Result register of the clock: holds one response until the consumer takes it.
// Depends on pic_pkg.
module pic_out_stage import pic_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  rsp_t rsp_in,
	output logic can_load,
	output logic valid,
	input  logic ready,
	output rsp_t rsp_s2
);

	logic valid_s2;

	assign can_load = !valid_s2 || ready;
	assign valid    = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (can_load) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			rsp_s2 <= rsp_in;
		end
	end

endmodule

// File: rtl/core/programmable_interval_clock.sv
// Programmable interval clock: tick, register read and register write requests.
// The update in pic_core fits between the input and the result register.
// Throughput: one request per cycle unless the result register stalls on rsp_ready low.
// Reset clears the clock registers and pipeline valids and loads the default divisors.
// Configuration writes are taken in every cycle (cfg_ready is tied high).
// Depends on pic_pkg, pic_core and pic_out_stage.
module programmable_interval_clock import pic_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [1:0]        op,
	input  logic [1:0]        reg_sel,
	input  logic [DATA_W-1:0] wdata,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [DATA_W-1:0] rdata,
	output logic              irq,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [DATA_W-1:0] cfg_data
);

	logic valid_s1;
	req_t req_s1;
	rsp_t rsp_comb;
	rsp_t rsp_s2;
	logic out_can_load;
	logic advance;

	assign advance   = valid_s1 && out_can_load;
	assign req_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= '{op: op, reg_sel: reg_sel, wdata: wdata};
		end
	end

	pic_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.req       (req_s1),
		.rsp       (rsp_comb),
		.cfg_en    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pic_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.rsp_in   (rsp_comb),
		.can_load (out_can_load),
		.valid    (rsp_valid),
		.ready    (rsp_ready),
		.rsp_s2   (rsp_s2)
	);

	assign rdata = rsp_s2.rdata;
	assign irq   = rsp_s2.irq;

endmodule

// File: rtl/core/pic_checker.sv
// Port-level checks for the programmable interval clock, bound to the top level.
// Depends on pic_pkg.
module pic_checker import pic_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic [1:0]        op,
	input logic [1:0]        reg_sel,
	input logic [DATA_W-1:0] wdata,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [DATA_W-1:0] rdata,
	input logic              irq,
	input logic              cfg_valid,
	input logic              cfg_ready,
	input logic [1:0]        cfg_index,
	input logic [DATA_W-1:0] cfg_data
);

	// an interrupt only comes from a tick, which never carries read data
	a_irq_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && irq |-> rdata == '0)
		else $error("irq response carries nonzero rdata");

	// with the result side empty, an accepted request goes through both registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !rsp_valid |-> ##2 rsp_valid)
		else $error("response missing two cycles after request");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rdata) && $stable(irq))
		else $error("stalled response changed");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind programmable_interval_clock pic_checker u_pic_checker (.*);
